[rtl/pcr_pkg.sv]
// Shared widths, payload types and helpers for the polyline cell rasterizer.
package pcr_pkg;

   localparam int GRID_SIZE = 32;
   localparam int COORD_W   = 5;
   localparam int ACC_W     = COORD_W + 1;

   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [ACC_W-1:0]   acc_type;

   typedef struct packed {
      coord_type row;
      coord_type col;
      logic      last;
   } cell_type;

   typedef struct packed {
      acc_type acc;
      logic    carry;
   } step_res_type;

   // Saturate a coordinate to the last grid cell.
   function automatic coord_type clamp_coord(input coord_type v);
      coord_type r;
      r = v;
      if ({1'b0, v} >= ACC_W'(GRID_SIZE)) begin
         r = COORD_W'(GRID_SIZE - 1);
      end
      return r;
   endfunction

endpackage

[rtl/pcr_ifs.sv]
// Handshake channels of the polyline cell rasterizer: vertex, cell and control write.
interface pcr_req_if;
   import pcr_pkg::*;
   logic      valid;
   logic      ready;
   coord_type vertex_row;
   coord_type vertex_col;
   modport source (output valid, output vertex_row, output vertex_col, input ready);
   modport sink   (input valid, input vertex_row, input vertex_col, output ready);
endinterface

interface pcr_rsp_if;
   import pcr_pkg::*;
   logic      valid;
   logic      ready;
   coord_type cell_row;
   coord_type cell_col;
   logic      last_of_run;
   modport source (output valid, output cell_row, output cell_col, output last_of_run,
                   input ready);
   modport sink   (input valid, input cell_row, input cell_col, input last_of_run,
                   output ready);
endinterface

interface pcr_csr_if;
   logic valid;
   logic ready;
   logic thick_mode;
   modport source (output valid, output thick_mode, input ready);
   modport sink   (input valid, input thick_mode, output ready);
endinterface

[rtl/pcr_step_unit.sv]
// Error accumulator step: add the minor span, wrap by the major span.
module pcr_step_unit (
   input  pcr_pkg::acc_type      acc,
   input  pcr_pkg::coord_type    major,
   input  pcr_pkg::coord_type    minor,
   output pcr_pkg::step_res_type res
);
   import pcr_pkg::*;

   acc_type sum;

   always_comb begin
      sum       = acc + {1'b0, minor};
      res.carry = (sum >= {1'b0, major});
      res.acc   = res.carry ? (sum - {1'b0, major}) : sum;
   end

endmodule

[rtl/pcr_out_buf.sv]
// One-entry output register for emitted cells.
module pcr_out_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  pcr_pkg::cell_type load_cell,
   input  logic              ready,
   output logic              valid,
   output pcr_pkg::cell_type out_item,
   output logic              slot_free
);
   import pcr_pkg::*;

   logic     valid_ff, valid_in;
   cell_type cell_ff, cell_in;

   assign slot_free = !valid_ff || ready;
   assign valid     = valid_ff;
   assign out_item  = cell_ff;

   always_comb begin
      valid_in = valid_ff && !ready;
      cell_in  = cell_ff;
      if (load) begin
         valid_in = 1'b1;
         cell_in  = load_cell;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cell_ff <= cell_in;
   end

endmodule

[rtl/polyline_cell_rasterizer.sv]
// Polyline cell rasterizer: turns polyline vertices into Bresenham-stepped grid cells.
// A vertex is taken only while the block is idle. The first vertex after reset comes
// out as one cell, through the S_FIRST state and then the output register. A vertex
// equal to the last emitted cell emits nothing and the block is ready again in the
// next cycle. Any other vertex is set up as it is taken and then emits its cells:
// d cells for a major span of d, plus one corner cell per diagonal step in thick
// mode, so at most 62 cells per vertex. The single stepper feeds one cell per cycle
// into the output register while the output is not stalled. The last cell of each
// vertex carries last_of_run. thick_mode is written on the csr channel, which is
// always ready; write it only while no vertex is in progress.
module polyline_cell_rasterizer (
   input  logic   clock,
   input  logic   reset,
   pcr_req_if.sink   req,
   pcr_rsp_if.source rsp,
   pcr_csr_if.sink   csr
);
   import pcr_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_FIRST = 2'd1;
   localparam logic [1:0] S_STEP  = 2'd2;
   localparam logic [1:0] S_MAIN  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       have_last_ff, have_last_in;
   coord_type  last_row_ff, last_row_in;
   coord_type  last_col_ff, last_col_in;
   logic       thick_ff, thick_in;
   coord_type  tr_ff, tr_in;
   coord_type  tc_ff, tc_in;
   acc_type    acc_ff, acc_in;
   coord_type  major_ff, major_in;
   coord_type  minor_ff, minor_in;
   coord_type  step_ff, step_in;
   logic       row_major_ff, row_major_in;
   logic       row_up_ff, row_up_in;
   logic       col_up_ff, col_up_in;
   coord_type  pend_r_ff, pend_r_in;
   coord_type  pend_c_ff, pend_c_in;
   logic       pend_last_ff, pend_last_in;

   coord_type    vr, vc;
   acc_type      diff_r, diff_c;
   coord_type    abs_r, abs_c;
   step_res_type sres;
   logic         final_step, diag;
   coord_type    next_r, next_c, step_r, step_c;
   logic         load;
   cell_type     load_cell, out_cell;
   logic         slot_free;

   assign req.ready = (state_ff == S_IDLE);
   assign csr.ready = 1'b1;

   pcr_step_unit u_step (
      .acc   (acc_ff),
      .major (major_ff),
      .minor (minor_ff),
      .res   (sres)
   );

   pcr_out_buf u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .load_cell (load_cell),
      .ready     (rsp.ready),
      .valid     (rsp.valid),
      .out_item  (out_cell),
      .slot_free (slot_free)
   );

   assign rsp.cell_row    = out_cell.row;
   assign rsp.cell_col    = out_cell.col;
   assign rsp.last_of_run = out_cell.last;

   // Setup arithmetic on the incoming vertex.
   always_comb begin
      vr     = clamp_coord(req.vertex_row);
      vc     = clamp_coord(req.vertex_col);
      diff_r = {1'b0, vr} - {1'b0, last_row_ff};
      diff_c = {1'b0, vc} - {1'b0, last_col_ff};
      abs_r  = diff_r[ACC_W-1] ? COORD_W'(-diff_r) : diff_r[COORD_W-1:0];
      abs_c  = diff_c[ACC_W-1] ? COORD_W'(-diff_c) : diff_c[COORD_W-1:0];
   end

   // Next cell along the line.
   always_comb begin
      step_r = row_up_ff ? (last_row_ff + COORD_W'(1)) : (last_row_ff - COORD_W'(1));
      step_c = col_up_ff ? (last_col_ff + COORD_W'(1)) : (last_col_ff - COORD_W'(1));
      final_step = (step_ff == major_ff);
      if (final_step) begin
         next_r = tr_ff;
         next_c = tc_ff;
      end else if (row_major_ff) begin
         next_r = step_r;
         next_c = sres.carry ? step_c : last_col_ff;
      end else begin
         next_c = step_c;
         next_r = sres.carry ? step_r : last_row_ff;
      end
      diag = thick_ff && (next_r != last_row_ff) && (next_c != last_col_ff);
   end

   always_comb begin
      state_in     = state_ff;
      have_last_in = have_last_ff;
      last_row_in  = last_row_ff;
      last_col_in  = last_col_ff;
      thick_in     = thick_ff;
      tr_in        = tr_ff;
      tc_in        = tc_ff;
      acc_in       = acc_ff;
      major_in     = major_ff;
      minor_in     = minor_ff;
      step_in      = step_ff;
      row_major_in = row_major_ff;
      row_up_in    = row_up_ff;
      col_up_in    = col_up_ff;
      pend_r_in    = pend_r_ff;
      pend_c_in    = pend_c_ff;
      pend_last_in = pend_last_ff;
      load         = 1'b0;
      load_cell    = '{row: next_r, col: next_c, last: final_step};

      if (csr.valid) begin
         thick_in = csr.thick_mode;
      end

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               tr_in = vr;
               tc_in = vc;
               if (!have_last_ff) begin
                  state_in = S_FIRST;
               end else if (vr != last_row_ff || vc != last_col_ff) begin
                  row_major_in = (abs_r > abs_c);
                  major_in     = (abs_r > abs_c) ? abs_r : abs_c;
                  minor_in     = (abs_r > abs_c) ? abs_c : abs_r;
                  acc_in       = {1'b0, ((abs_r > abs_c) ? abs_r : abs_c) >> 1};
                  row_up_in    = !diff_r[ACC_W-1] && (abs_r != '0);
                  col_up_in    = !diff_c[ACC_W-1] && (abs_c != '0);
                  step_in      = COORD_W'(1);
                  state_in     = S_STEP;
               end
            end
         end
         S_FIRST: begin
            load_cell = '{row: tr_ff, col: tc_ff, last: 1'b1};
            if (slot_free) begin
               load         = 1'b1;
               last_row_in  = tr_ff;
               last_col_in  = tc_ff;
               have_last_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_STEP: begin
            if (slot_free) begin
               load    = 1'b1;
               acc_in  = sres.acc;
               step_in = step_ff + COORD_W'(1);
               if (diag) begin
                  // Corner cell first: previous row, new column.
                  load_cell    = '{row: last_row_ff, col: next_c, last: 1'b0};
                  last_col_in  = next_c;
                  pend_r_in    = next_r;
                  pend_c_in    = next_c;
                  pend_last_in = final_step;
                  state_in     = S_MAIN;
               end else begin
                  last_row_in = next_r;
                  last_col_in = next_c;
                  if (final_step) begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         S_MAIN: begin
            load_cell = '{row: pend_r_ff, col: pend_c_ff, last: pend_last_ff};
            if (slot_free) begin
               load        = 1'b1;
               last_row_in = pend_r_ff;
               last_col_in = pend_c_ff;
               state_in    = pend_last_ff ? S_IDLE : S_STEP;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         have_last_ff <= 1'b0;
         last_row_ff  <= '0;
         last_col_ff  <= '0;
         thick_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         have_last_ff <= have_last_in;
         last_row_ff  <= last_row_in;
         last_col_ff  <= last_col_in;
         thick_ff     <= thick_in;
      end
      tr_ff        <= tr_in;
      tc_ff        <= tc_in;
      acc_ff       <= acc_in;
      major_ff     <= major_in;
      minor_ff     <= minor_in;
      step_ff      <= step_in;
      row_major_ff <= row_major_in;
      row_up_ff    <= row_up_in;
      col_up_ff    <= col_up_in;
      pend_r_ff    <= pend_r_in;
      pend_c_ff    <= pend_c_in;
      pend_last_ff <= pend_last_in;
   end

endmodule
